// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/mims_pkg.sv
// ----------------------------------------------------------------------------
// mims_pkg
// Types and fixed constants of the moving inversion march sequencer.
// ----------------------------------------------------------------------------
package mims_pkg;

    localparam int DATA_W   = 64;
    localparam int REPEAT_W = 32;
    localparam int BASE_W   = 24;
    localparam int WCOUNT_W = 25;
    localparam int WALK_W   = 6;
    localparam int PADDR_W  = 6;
    localparam int PDATA_W  = 64;

    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 32'd1;
    localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 25'h1000000;

    // Register indexes, one 64-bit slot each (byte address 8 * index)
    localparam logic [2:0] REG_TEST_MODE     = 3'd0;
    localparam logic [2:0] REG_START_PATTERN = 3'd1;
    localparam logic [2:0] REG_REPEAT_COUNT  = 3'd2;
    localparam logic [2:0] REG_REGION_BASE   = 3'd3;
    localparam logic [2:0] REG_WORD_COUNT    = 3'd4;
    localparam logic [2:0] REG_STOP_ON_ERROR = 3'd5;

    typedef enum logic [1:0] {
        PH_FILL    = 2'd0,
        PH_INVERT  = 2'd1,
        PH_RESTORE = 2'd2,
        PH_FINAL   = 2'd3
    } phase_t;

endpackage

// File: design/moving_inversion_march_sequencer.sv
// ----------------------------------------------------------------------------
// moving_inversion_march_sequencer
// Memory self-test sequencer running a moving inversion march. Every input
// word carries the data read back at the address shown by the previous
// result; every result word names one memory access (address, write enable,
// write data) plus the check of that read against the expected value. A pass
// fills the region ascending with pattern P, checks P while writing ~P
// ascending, checks ~P while writing P descending, then checks P ascending.
// Mode 0 repeats passes and inverts P after each; mode 1 walks a single one
// through all 64 bit positions per repeat. Mismatches are counted with
// saturation and can stop the test. Once the test has ended, every word
// reports done with no access (address zero) until start_req restarts it.
// The block takes one word per cycle unless the input side stalls: an input
// register and a result register frame the sequencing logic, and the state
// registers (phase, offset, pattern, repeat and error counters) update as a
// word moves from the input register to the result register. The input side
// stalls only while both registers hold a word and the result side stalls.
// Configuration must be written through the APB port only while no word is
// in flight; the block itself does not enforce this. start_pattern takes
// effect at the next restart (start_req set), all other registers at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module moving_inversion_march_sequencer
    import mims_pkg::*;
#(
    parameter int ADDR_WIDTH        = 24,
    parameter int ERROR_COUNT_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // input word channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         start_req,
    input  logic [DATA_W-1:0]            read_data,

    // result word channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [ADDR_WIDTH-1:0]        address,
    output logic                         write_enable,
    output logic [DATA_W-1:0]            write_data,
    output logic                         compared,
    output logic [DATA_W-1:0]            expected_data,
    output logic                         mismatch,
    output logic [1:0]                   march_phase,
    output logic [DATA_W-1:0]            active_pattern,
    output logic [ERROR_COUNT_WIDTH-1:0] error_total,
    output logic                         test_done,

    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready
);

    localparam int SUM_W = ((ADDR_WIDTH > WCOUNT_W) ? ADDR_WIDTH : WCOUNT_W) + 1;
    localparam logic [63:0] ADDR_SPAN = 64'd1 << ADDR_WIDTH;
    localparam logic [ERROR_COUNT_WIDTH-1:0] ERR_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                test_mode_reg;
    logic [DATA_W-1:0]   start_pattern_reg;
    logic [REPEAT_W-1:0] repeat_count_reg;
    logic [BASE_W-1:0]   region_base_reg;
    logic [WCOUNT_W-1:0] word_count_reg;
    logic                stop_on_error_reg;

    logic                cfg_write;
    logic [2:0]          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_mode_reg     <= 1'b0;
            start_pattern_reg <= '0;
            repeat_count_reg  <= REPEAT_RESET;
            region_base_reg   <= '0;
            word_count_reg    <= WCOUNT_RESET;
            stop_on_error_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TEST_MODE:     test_mode_reg     <= pwdata[0];
                REG_START_PATTERN: start_pattern_reg <= pwdata;
                REG_REPEAT_COUNT:  repeat_count_reg  <= pwdata[REPEAT_W-1:0];
                REG_REGION_BASE:   region_base_reg   <= pwdata[BASE_W-1:0];
                REG_WORD_COUNT:    word_count_reg    <= pwdata[WCOUNT_W-1:0];
                REG_STOP_ON_ERROR: stop_on_error_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_TEST_MODE:     prdata = PDATA_W'(test_mode_reg);
            REG_START_PATTERN: prdata = start_pattern_reg;
            REG_REPEAT_COUNT:  prdata = PDATA_W'(repeat_count_reg);
            REG_REGION_BASE:   prdata = PDATA_W'(region_base_reg);
            REG_WORD_COUNT:    prdata = PDATA_W'(word_count_reg);
            REG_STOP_ON_ERROR: prdata = PDATA_W'(stop_on_error_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_start_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic              result_valid_reg;
    logic              advance;
    logic              fire;
    logic              item_take;

    // The result register can take a new word when empty or being drained
    assign advance    = !result_valid_reg || !result_stall;
    assign fire       = s1_valid_reg && advance;
    assign item_stall = s1_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_start_reg <= start_req;
            s1_data_reg  <= read_data;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    phase_t                       phase_reg,   phase_next;
    logic [WCOUNT_W-1:0]          offset_reg,  offset_next;
    logic [DATA_W-1:0]            pattern_reg, pattern_next;
    logic [REPEAT_W-1:0]          repeats_reg, repeats_next;
    logic [WALK_W-1:0]            walk_reg,    walk_next;
    logic [ERROR_COUNT_WIDTH-1:0] errors_reg,  errors_next;
    logic                         running_reg, running_next;

    // State as seen by this word: a restart request resets it first
    phase_t                       eff_phase;
    logic [WCOUNT_W-1:0]          eff_offset;
    logic [DATA_W-1:0]            eff_pattern;
    logic [REPEAT_W-1:0]          eff_repeats;
    logic [WALK_W-1:0]            eff_walk;
    logic [ERROR_COUNT_WIDTH-1:0] eff_errors;
    logic                         eff_running;

    always_comb
    begin
        if (s1_start_reg)
        begin
            eff_phase   = PH_FILL;
            eff_offset  = '0;
            eff_pattern = start_pattern_reg;
            eff_repeats = '0;
            eff_walk    = '0;
            eff_errors  = '0;
            eff_running = 1'b1;
        end
        else
        begin
            eff_phase   = phase_reg;
            eff_offset  = offset_reg;
            eff_pattern = pattern_reg;
            eff_repeats = repeats_reg;
            eff_walk    = walk_reg;
            eff_errors  = errors_reg;
            eff_running = running_reg;
        end
    end

    // ------------------------------------------------------------------
    // Region size and clamped offset
    // ------------------------------------------------------------------
    logic [WCOUNT_W-1:0] wc_nz;
    logic [WCOUNT_W-1:0] span;
    logic [WCOUNT_W-1:0] last_idx;
    logic [WCOUNT_W-1:0] off_cl;
    logic                off_last;

    always_comb
    begin
        // zero words means one, more than the address space means all of it
        wc_nz = (word_count_reg == '0) ? WCOUNT_W'(1) : word_count_reg;
        if (64'(wc_nz) > ADDR_SPAN)
        begin
            span = ADDR_SPAN[WCOUNT_W-1:0];
        end
        else
        begin
            span = wc_nz;
        end
        last_idx = span - WCOUNT_W'(1);
        // an offset left beyond a shrunk region counts as the last word
        off_cl   = (eff_offset >= span) ? last_idx : eff_offset;
        off_last = (off_cl == last_idx);
    end

    // ------------------------------------------------------------------
    // Access and check for this word
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]   pat;
    logic [WCOUNT_W-1:0] idx;
    logic [SUM_W-1:0]    addr_sum;
    logic                acc_we;
    logic [DATA_W-1:0]   acc_wdata;
    logic                acc_cmp;
    logic [DATA_W-1:0]   acc_exp;
    logic                acc_mis;

    assign pat = test_mode_reg ? (DATA_W'(1) << eff_walk) : eff_pattern;

    always_comb
    begin
        idx       = off_cl;
        acc_we    = 1'b0;
        acc_wdata = '0;
        acc_cmp   = 1'b0;
        acc_exp   = '0;
        if (eff_running)
        begin
            case (eff_phase)
                PH_FILL:
                begin
                    acc_we    = 1'b1;
                    acc_wdata = pat;
                end
                PH_INVERT:
                begin
                    acc_we    = 1'b1;
                    acc_wdata = ~pat;
                    acc_cmp   = 1'b1;
                    acc_exp   = pat;
                end
                PH_RESTORE:
                begin
                    // descending sweep
                    idx       = last_idx - off_cl;
                    acc_we    = 1'b1;
                    acc_wdata = pat;
                    acc_cmp   = 1'b1;
                    acc_exp   = ~pat;
                end
                default:
                begin
                    acc_cmp = 1'b1;
                    acc_exp = pat;
                end
            endcase
        end
        if (eff_running)
        begin
            addr_sum = SUM_W'(region_base_reg) + SUM_W'(idx);
        end
        else
        begin
            // stopped: no access, show address zero
            addr_sum = '0;
        end
        acc_mis  = acc_cmp && (s1_data_reg != acc_exp);
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic [REPEAT_W-1:0] reps_target;
    logic [REPEAT_W-1:0] reps_inc;
    logic                reps_hit;
    logic                done;

    assign reps_target = (repeat_count_reg == '0) ? REPEAT_W'(1) : repeat_count_reg;
    assign reps_inc    = eff_repeats + REPEAT_W'(1);
    assign reps_hit    = (reps_inc >= reps_target);

    always_comb
    begin
        phase_next   = eff_phase;
        offset_next  = eff_offset;
        pattern_next = eff_pattern;
        repeats_next = eff_repeats;
        walk_next    = eff_walk;
        errors_next  = eff_errors;
        done         = !eff_running;
        if (eff_running)
        begin
            if (acc_mis)
            begin
                if (eff_errors != ERR_MAX)
                begin
                    errors_next = eff_errors + ERROR_COUNT_WIDTH'(1);
                end
                if (stop_on_error_reg)
                begin
                    done = 1'b1;
                end
            end
            if (off_last)
            begin
                offset_next = '0;
                phase_next  = phase_t'(2'(eff_phase + 2'd1));
                if (eff_phase == PH_FINAL)
                begin
                    if (test_mode_reg)
                    begin
                        // one repeat is done once the one has walked all bits
                        walk_next = eff_walk + WALK_W'(1);
                        if (eff_walk == '1)
                        begin
                            repeats_next = reps_inc;
                            if (reps_hit)
                            begin
                                done = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        pattern_next = ~eff_pattern;
                        repeats_next = reps_inc;
                        if (reps_hit)
                        begin
                            done = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                offset_next = off_cl + WCOUNT_W'(1);
            end
        end
        running_next = eff_running && !done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FILL;
            offset_reg  <= '0;
            pattern_reg <= '0;
            repeats_reg <= '0;
            walk_reg    <= '0;
            errors_reg  <= '0;
            running_reg <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            pattern_reg <= pattern_next;
            repeats_reg <= repeats_next;
            walk_reg    <= walk_next;
            errors_reg  <= errors_next;
            running_reg <= running_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [ADDR_WIDTH-1:0]        address_reg;
    logic                         write_enable_reg;
    logic [DATA_W-1:0]            write_data_reg;
    logic                         compared_reg;
    logic [DATA_W-1:0]            expected_data_reg;
    logic                         mismatch_reg;
    logic [1:0]                   march_phase_reg;
    logic [DATA_W-1:0]            active_pattern_reg;
    logic [ERROR_COUNT_WIDTH-1:0] error_total_reg;
    logic                         test_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            address_reg        <= addr_sum[ADDR_WIDTH-1:0];
            write_enable_reg   <= acc_we;
            write_data_reg     <= acc_wdata;
            compared_reg       <= acc_cmp;
            expected_data_reg  <= acc_exp;
            mismatch_reg       <= acc_mis;
            march_phase_reg    <= eff_phase;
            active_pattern_reg <= pat;
            error_total_reg    <= errors_next;
            test_done_reg      <= done;
        end
    end

    assign result_valid   = result_valid_reg;
    assign address        = address_reg;
    assign write_enable   = write_enable_reg;
    assign write_data     = write_data_reg;
    assign compared       = compared_reg;
    assign expected_data  = expected_data_reg;
    assign mismatch       = mismatch_reg;
    assign march_phase    = march_phase_reg;
    assign active_pattern = active_pattern_reg;
    assign error_total    = error_total_reg;
    assign test_done      = test_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_SAME(a_final_no_write, clk, rst_n,
        result_valid_reg && (march_phase_reg == PH_FINAL), !write_enable_reg)
    `ASSERT_SAME(a_mismatch_needs_check, clk, rst_n,
        result_valid_reg && mismatch_reg, compared_reg && !(march_phase_reg == PH_FILL))
    `ASSERT_NEXT(a_errors_monotonic, clk, rst_n,
        fire && !s1_start_reg, errors_reg >= $past(errors_reg))
    `ASSERT_NEXT(a_stopped_stays, clk, rst_n,
        !running_reg && !(fire && s1_start_reg), !running_reg)
    `ASSERT_SAME(a_stall_only_when_full, clk, rst_n,
        item_stall, s1_valid_reg && result_valid_reg)

endmodule
